// ===== rtl/owm_pkg.sv =====
// Shared types and constants of the 1-Wire bus master.
package owm_pkg;

  localparam int unsigned TickW  = 10;
  localparam int unsigned CfgIdxW = 3;
  localparam int unsigned NumRegs = 7;

  // Command codes carried in the func field.
  localparam logic [1:0] FUNC_TICK  = 2'd0;
  localparam logic [1:0] FUNC_RESET = 2'd1;
  localparam logic [1:0] FUNC_WRITE = 2'd2;
  localparam logic [1:0] FUNC_READ  = 2'd3;

  // Bus phase codes.
  localparam logic [2:0] PH_IDLE     = 3'd0;
  localparam logic [2:0] PH_RST_LOW  = 3'd1;
  localparam logic [2:0] PH_RST_WAIT = 3'd2;
  localparam logic [2:0] PH_RST_REC  = 3'd3;
  localparam logic [2:0] PH_WR_LOW   = 3'd4;
  localparam logic [2:0] PH_WR_REL   = 3'd5;
  localparam logic [2:0] PH_RD_LOW   = 3'd6;
  localparam logic [2:0] PH_RD_REL   = 3'd7;

  // Configuration register indexes.
  localparam logic [CfgIdxW-1:0] REG_RESET_LOW     = 3'd0;
  localparam logic [CfgIdxW-1:0] REG_PRESENCE_WAIT = 3'd1;
  localparam logic [CfgIdxW-1:0] REG_RESET_RECOVER = 3'd2;
  localparam logic [CfgIdxW-1:0] REG_WRITE_ONE_LOW = 3'd3;
  localparam logic [CfgIdxW-1:0] REG_WRITE_SLOT    = 3'd4;
  localparam logic [CfgIdxW-1:0] REG_READ_LOW      = 3'd5;
  localparam logic [CfgIdxW-1:0] REG_READ_RECOVER  = 3'd6;

  // Register values after reset.
  localparam logic [TickW-1:0] RST_RESET_LOW     = 10'd480;
  localparam logic [TickW-1:0] RST_PRESENCE_WAIT = 10'd80;
  localparam logic [TickW-1:0] RST_RESET_RECOVER = 10'd400;
  localparam logic [TickW-1:0] RST_WRITE_ONE_LOW = 10'd1;
  localparam logic [TickW-1:0] RST_WRITE_SLOT    = 10'd50;
  localparam logic [TickW-1:0] RST_READ_LOW      = 10'd2;
  localparam logic [TickW-1:0] RST_READ_RECOVER  = 10'd60;

  typedef struct packed {
    logic [TickW-1:0] reset_low;
    logic [TickW-1:0] presence_wait;
    logic [TickW-1:0] reset_recover;
    logic [TickW-1:0] write_one_low;
    logic [TickW-1:0] write_slot;
    logic [TickW-1:0] read_low;
    logic [TickW-1:0] read_recover;
  } cfg_t;

  typedef struct packed {
    logic [2:0]       phase;
    logic [TickW-1:0] tick_count;
    logic [2:0]       bit_index;
    logic [7:0]       shift_byte;
    logic             presence_flag;
    logic [1:0]       op_kind;
    logic [7:0]       read_result;
  } state_t;

  typedef struct packed {
    logic [1:0] func;
    logic [7:0] write_byte;
    logic       line_level;
  } item_t;

  typedef struct packed {
    logic       drive_low;
    logic       busy_res;
    logic       done_res;
    logic [7:0] read_byte;
    logic       presence;
  } result_t;

endpackage

// ===== rtl/owm_if.sv =====
// Valid/ready channel interfaces for tick items and result items.
interface owm_item_if;
  logic       valid;
  logic       ready;
  logic [1:0] func;
  logic [7:0] write_byte;
  logic       line_level;

  modport source (output valid, output func, output write_byte, output line_level,
                  input ready);
  modport sink (input valid, input func, input write_byte, input line_level,
                output ready);
endinterface

interface owm_res_if;
  logic       valid;
  logic       ready;
  logic       drive_low;
  logic       busy_res;
  logic       done_res;
  logic [7:0] read_byte;
  logic       presence;

  modport source (output valid, output drive_low, output busy_res, output done_res,
                  output read_byte, output presence, input ready);
  modport sink (input valid, input drive_low, input busy_res, input done_res,
                input read_byte, input presence, output ready);
endinterface

// ===== rtl/owm_cfg.sv =====
// Timing configuration registers of the 1-Wire bus master.
module owm_cfg (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         we_i,
  input  logic [owm_pkg::CfgIdxW-1:0]  idx_i,
  input  logic [owm_pkg::TickW-1:0]    data_i,
  output owm_pkg::cfg_t                cfg_o
);

  owm_pkg::cfg_t cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.reset_low     <= owm_pkg::RST_RESET_LOW;
      cfg_q.presence_wait <= owm_pkg::RST_PRESENCE_WAIT;
      cfg_q.reset_recover <= owm_pkg::RST_RESET_RECOVER;
      cfg_q.write_one_low <= owm_pkg::RST_WRITE_ONE_LOW;
      cfg_q.write_slot    <= owm_pkg::RST_WRITE_SLOT;
      cfg_q.read_low      <= owm_pkg::RST_READ_LOW;
      cfg_q.read_recover  <= owm_pkg::RST_READ_RECOVER;
    end else if (we_i) begin
      case (idx_i)
        owm_pkg::REG_RESET_LOW:     cfg_q.reset_low     <= data_i;
        owm_pkg::REG_PRESENCE_WAIT: cfg_q.presence_wait <= data_i;
        owm_pkg::REG_RESET_RECOVER: cfg_q.reset_recover <= data_i;
        owm_pkg::REG_WRITE_ONE_LOW: cfg_q.write_one_low <= data_i;
        owm_pkg::REG_WRITE_SLOT:    cfg_q.write_slot    <= data_i;
        owm_pkg::REG_READ_LOW:      cfg_q.read_low      <= data_i;
        owm_pkg::REG_READ_RECOVER:  cfg_q.read_recover  <= data_i;
        default: ;
      endcase
    end
  end

  assign cfg_o = cfg_q;

endmodule

// ===== rtl/owm_step.sv =====
// Next-state and result logic for one microsecond tick of the bus master.
module owm_step (
  input  owm_pkg::cfg_t    cfg_i,
  input  owm_pkg::state_t  state_i,
  input  owm_pkg::item_t   item_i,
  output owm_pkg::state_t  state_o,
  output owm_pkg::result_t res_o
);

  owm_pkg::state_t        st;
  logic [owm_pkg::TickW:0] tick_inc;
  logic                   bit_val;
  logic                   drive;
  logic                   finish;

  always_comb begin
    st       = state_i;
    drive    = 1'b0;
    finish   = 1'b0;
    tick_inc = '0;
    bit_val  = 1'b0;

    // A command is taken only from idle; its first tick is this one.
    if (st.phase == owm_pkg::PH_IDLE && item_i.func != owm_pkg::FUNC_TICK) begin
      st.op_kind    = item_i.func;
      st.bit_index  = '0;
      st.tick_count = '0;
      st.shift_byte = (item_i.func == owm_pkg::FUNC_WRITE) ? item_i.write_byte : 8'h00;
      case (item_i.func)
        owm_pkg::FUNC_RESET: st.phase = owm_pkg::PH_RST_LOW;
        owm_pkg::FUNC_WRITE: st.phase = owm_pkg::PH_WR_LOW;
        default:             st.phase = owm_pkg::PH_RD_LOW;
      endcase
    end

    tick_inc = {1'b0, st.tick_count} + 1'b1;
    bit_val  = st.shift_byte[st.bit_index];

    case (st.phase)
      owm_pkg::PH_RST_LOW: begin
        drive         = 1'b1;
        st.tick_count = tick_inc[owm_pkg::TickW-1:0];
        if (tick_inc >= {1'b0, cfg_i.reset_low}) begin
          st.phase      = owm_pkg::PH_RST_WAIT;
          st.tick_count = '0;
        end
      end
      owm_pkg::PH_RST_WAIT: begin
        if (st.tick_count >= cfg_i.presence_wait) begin
          st.presence_flag = ~item_i.line_level;
          if (cfg_i.reset_recover == '0) begin
            finish = 1'b1;
          end else begin
            st.phase      = owm_pkg::PH_RST_REC;
            st.tick_count = '0;
          end
        end else begin
          st.tick_count = tick_inc[owm_pkg::TickW-1:0];
        end
      end
      owm_pkg::PH_RST_REC: begin
        st.tick_count = tick_inc[owm_pkg::TickW-1:0];
        if (tick_inc >= {1'b0, cfg_i.reset_recover}) begin
          finish = 1'b1;
        end
      end
      owm_pkg::PH_WR_LOW: begin
        drive         = 1'b1;
        st.tick_count = tick_inc[owm_pkg::TickW-1:0];
        if (tick_inc >= {1'b0, (bit_val ? cfg_i.write_one_low : cfg_i.write_slot)}) begin
          st.phase      = owm_pkg::PH_WR_REL;
          st.tick_count = '0;
        end
      end
      owm_pkg::PH_WR_REL: begin
        st.tick_count = tick_inc[owm_pkg::TickW-1:0];
        // A zero bit is followed by a single released tick.
        if (tick_inc >= (bit_val ? {1'b0, cfg_i.write_slot}
                                 : {{owm_pkg::TickW{1'b0}}, 1'b1})) begin
          if (st.bit_index == 3'd7) begin
            finish = 1'b1;
          end else begin
            st.bit_index  = st.bit_index + 3'd1;
            st.phase      = owm_pkg::PH_WR_LOW;
            st.tick_count = '0;
          end
        end
      end
      owm_pkg::PH_RD_LOW: begin
        drive         = 1'b1;
        st.tick_count = tick_inc[owm_pkg::TickW-1:0];
        if (tick_inc >= {1'b0, cfg_i.read_low}) begin
          st.phase      = owm_pkg::PH_RD_REL;
          st.tick_count = '0;
        end
      end
      owm_pkg::PH_RD_REL: begin
        // The line is sampled on the first released tick of the slot.
        if (st.tick_count == '0) begin
          st.shift_byte[st.bit_index] = st.shift_byte[st.bit_index] | item_i.line_level;
        end
        if (st.tick_count >= cfg_i.read_recover) begin
          if (st.bit_index == 3'd7) begin
            finish = 1'b1;
          end else begin
            st.bit_index  = st.bit_index + 3'd1;
            st.phase      = owm_pkg::PH_RD_LOW;
            st.tick_count = '0;
          end
        end else begin
          st.tick_count = tick_inc[owm_pkg::TickW-1:0];
        end
      end
      default: ;
    endcase

    if (finish) begin
      if (st.op_kind == owm_pkg::FUNC_READ) begin
        st.read_result = st.shift_byte;
      end
      st.phase      = owm_pkg::PH_IDLE;
      st.tick_count = '0;
    end

    state_o         = st;
    res_o.drive_low = drive;
    res_o.busy_res  = (st.phase != owm_pkg::PH_IDLE);
    res_o.done_res  = finish;
    res_o.read_byte = st.read_result;
    res_o.presence  = st.presence_flag;
  end

endmodule

// ===== rtl/one_wire_bus_master.sv =====
// Top level of the 1-Wire bus master: input register, tick logic and result register.
//
// Each tick item stands for one microsecond of bus time. The block takes one tick
// item per clock cycle unless the result side stalls, and returns exactly one
// result item for it, in order; the result describes the bus level the master
// drives on that tick, whether a command is still running afterwards, a one-tick
// done flag, the last read byte and the last presence result. A tick item goes
// through two registers: it is captured in an input register, then the tick logic
// computes the new bus state and the result combinationally and the result lands
// in the output register. The state that each tick leaves is fed to the next. When
// the result side stalls, the input register fills and then input ready drops. A
// command (reset, write byte, read byte) is started by the func field only while
// the bus is idle; one that arrives while a command runs, including on its done
// tick, is dropped. The seven timing registers are written through the cfg port at
// any edge where cfg_we_i is high and should only be changed while no tick item is
// in flight; indexes past the last register are ignored.
module one_wire_bus_master (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  owm_item_if.sink                     item_i,
  owm_res_if.source                    res_o,
  input  logic                         cfg_we_i,
  input  logic [owm_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [owm_pkg::TickW-1:0]    cfg_data_i
);

  owm_pkg::cfg_t    cfg;
  owm_pkg::state_t  state_q, state_d;
  owm_pkg::item_t   in_q;
  owm_pkg::result_t res_q, res_d;
  logic             in_valid_q;
  logic             out_valid_q;
  logic             advance;

  owm_cfg u_cfg (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .we_i   (cfg_we_i),
    .idx_i  (cfg_idx_i),
    .data_i (cfg_data_i),
    .cfg_o  (cfg)
  );

  // The held tick moves on when the result register is empty or being emptied.
  assign advance      = in_valid_q && (!out_valid_q || res_o.ready);
  assign item_i.ready = !in_valid_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (item_i.ready) begin
      in_valid_q <= item_i.valid;
    end
  end

  // The payload needs no reset; it is only used while the valid flag is set.
  always_ff @(posedge clk_i) begin
    if (item_i.ready && item_i.valid) begin
      in_q.func       <= item_i.func;
      in_q.write_byte <= item_i.write_byte;
      in_q.line_level <= item_i.line_level;
    end
  end

  owm_step u_step (
    .cfg_i   (cfg),
    .state_i (state_q),
    .item_i  (in_q),
    .state_o (state_d),
    .res_o   (res_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q.phase         <= owm_pkg::PH_IDLE;
      state_q.tick_count    <= '0;
      state_q.bit_index     <= '0;
      state_q.shift_byte    <= '0;
      state_q.presence_flag <= 1'b0;
      state_q.op_kind       <= owm_pkg::FUNC_TICK;
      state_q.read_result   <= '0;
    end else if (advance) begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= 1'b1;
    end else if (res_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      res_q <= res_d;
    end
  end

  assign res_o.valid     = out_valid_q;
  assign res_o.drive_low = res_q.drive_low;
  assign res_o.busy_res  = res_q.busy_res;
  assign res_o.done_res  = res_q.done_res;
  assign res_o.read_byte = res_q.read_byte;
  assign res_o.presence  = res_q.presence;

endmodule

// ===== rtl/owm_checker.sv =====
// Port-level assertions for the 1-Wire bus master and their bind.
module owm_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       item_ready,
  input logic       res_valid,
  input logic       res_ready,
  input logic       drive_low,
  input logic       busy_res,
  input logic       done_res,
  input logic [7:0] read_byte,
  input logic       presence
);

  // A finished command never reports itself as still running.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid |-> !(done_res && busy_res))
    else $error("done and busy reported together");

  // The bus is only pulled low while a command is in progress.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid && drive_low) |-> busy_res)
    else $error("bus driven low outside a command");

  // Input stalls come only from a stalled result side.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !item_ready |-> (res_valid && !res_ready))
    else $error("input stalled without output back-pressure");

  // A stalled result holds its contents.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid && !res_ready) |=> (res_valid && $stable(drive_low) && $stable(busy_res)
      && $stable(done_res) && $stable(read_byte) && $stable(presence)))
    else $error("stalled result changed");

endmodule

bind one_wire_bus_master owm_checker u_owm_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .item_ready (item_i.ready),
  .res_valid  (res_o.valid),
  .res_ready  (res_o.ready),
  .drive_low  (res_o.drive_low),
  .busy_res   (res_o.busy_res),
  .done_res   (res_o.done_res),
  .read_byte  (res_o.read_byte),
  .presence   (res_o.presence)
);

// ===== tb/one_wire_bus_master_tb.sv =====
// Self-checking testbench for the 1-Wire bus master: directed commands, zero timing, random ticks.
module one_wire_bus_master_tb;
  timeunit 1ns;
  timeprecision 1ps;

  // Clock, reset and the configuration write port. Every input of the block is
  // given a known value at time zero.
  logic                        clk = 1'b0;
  logic                        rst_n = 1'b0;
  logic                        cfg_we = 1'b0;
  logic [owm_pkg::CfgIdxW-1:0] cfg_idx = '0;
  logic [owm_pkg::TickW-1:0]   cfg_data = '0;

  owm_item_if tick_ch ();
  owm_res_if  res_ch ();

  one_wire_bus_master i_dut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .item_i     (tick_ch),
    .res_o      (res_ch),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_data_i (cfg_data)
  );

  always #5 clk = ~clk;

  // Shadow copy of the bus master. It is advanced once per accepted tick item and
  // holds the same timing registers that were written into the block.
  owm_pkg::cfg_t             timing;
  logic [2:0]                bus_phase;
  logic [owm_pkg::TickW-1:0] tick_cnt;
  logic [2:0]                bit_idx;
  logic [7:0]                shift_reg;
  logic                      presence_seen;
  logic [1:0]                cmd_kind;
  logic [7:0]                last_read;

  // Bus results that the shadow copy has produced and the block still owes us.
  owm_pkg::result_t bus_outcome_q[$];

  // When low, neither side inserts gaps or stalls.
  bit idle_on = 1'b1;

  int unsigned n_ticks    = 0;
  int unsigned n_checked  = 0;
  int unsigned n_errors   = 0;
  int unsigned n_resets   = 0;
  int unsigned n_writes   = 0;
  int unsigned n_reads    = 0;
  int unsigned n_settings = 0;

  // ---------------------------------------------------------------------------
  // Shadow model of one microsecond tick.
  // ---------------------------------------------------------------------------

  function automatic void enter_phase(logic [2:0] next_phase);
    bus_phase = next_phase;
    tick_cnt  = '0;
  endfunction

  // Closes the running command. A read command latches its assembled byte.
  function automatic logic end_command();
    if (cmd_kind == owm_pkg::FUNC_READ) begin
      last_read = shift_reg;
    end
    bus_phase = owm_pkg::PH_IDLE;
    tick_cnt  = '0;
    return 1'b1;
  endfunction

  // Moves to the next bit slot, or ends the command after the eighth one.
  function automatic logic next_slot(logic [2:0] low_phase);
    if (bit_idx >= 3'd7) begin
      return end_command();
    end
    bit_idx++;
    enter_phase(low_phase);
    return 1'b0;
  endfunction

  function automatic owm_pkg::result_t advance_bus(owm_pkg::item_t it);
    logic             drive;
    logic             done;
    logic             bit_val;
    owm_pkg::result_t rep;
    drive = 1'b0;
    done  = 1'b0;
    // A command only starts from idle; its first tick is the one it comes with.
    if (bus_phase == owm_pkg::PH_IDLE && it.func != owm_pkg::FUNC_TICK) begin
      cmd_kind  = it.func;
      bit_idx   = '0;
      shift_reg = (it.func == owm_pkg::FUNC_WRITE) ? it.write_byte : 8'h00;
      case (it.func)
        owm_pkg::FUNC_RESET: begin
          enter_phase(owm_pkg::PH_RST_LOW);
          n_resets++;
        end
        owm_pkg::FUNC_WRITE: begin
          enter_phase(owm_pkg::PH_WR_LOW);
          n_writes++;
        end
        default: begin
          enter_phase(owm_pkg::PH_RD_LOW);
          n_reads++;
        end
      endcase
    end
    bit_val = shift_reg[bit_idx];
    case (bus_phase)
      owm_pkg::PH_RST_LOW: begin
        drive = 1'b1;
        tick_cnt++;
        if (tick_cnt >= timing.reset_low) enter_phase(owm_pkg::PH_RST_WAIT);
      end
      owm_pkg::PH_RST_WAIT: begin
        // The presence pulse is sampled once the wait has run out.
        if (tick_cnt >= timing.presence_wait) begin
          presence_seen = ~it.line_level;
          if (timing.reset_recover == '0) begin
            done = end_command();
          end else begin
            enter_phase(owm_pkg::PH_RST_REC);
          end
        end else begin
          tick_cnt++;
        end
      end
      owm_pkg::PH_RST_REC: begin
        tick_cnt++;
        if (tick_cnt >= timing.reset_recover) done = end_command();
      end
      owm_pkg::PH_WR_LOW: begin
        drive = 1'b1;
        tick_cnt++;
        if (tick_cnt >= (bit_val ? timing.write_one_low : timing.write_slot)) begin
          enter_phase(owm_pkg::PH_WR_REL);
        end
      end
      owm_pkg::PH_WR_REL: begin
        // A zero bit is followed by a single released tick.
        tick_cnt++;
        if (tick_cnt >= (bit_val ? timing.write_slot : 10'd1)) begin
          done = next_slot(owm_pkg::PH_WR_LOW);
        end
      end
      owm_pkg::PH_RD_LOW: begin
        drive = 1'b1;
        tick_cnt++;
        if (tick_cnt >= timing.read_low) enter_phase(owm_pkg::PH_RD_REL);
      end
      owm_pkg::PH_RD_REL: begin
        // The data bit is taken on the first released tick of the slot.
        if (tick_cnt == '0) shift_reg[bit_idx] = shift_reg[bit_idx] | it.line_level;
        if (tick_cnt >= timing.read_recover) begin
          done = next_slot(owm_pkg::PH_RD_LOW);
        end else begin
          tick_cnt++;
        end
      end
      default: ;
    endcase
    rep.drive_low = drive;
    rep.busy_res  = (bus_phase != owm_pkg::PH_IDLE);
    rep.done_res  = done;
    rep.read_byte = last_read;
    rep.presence  = presence_seen;
    return rep;
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus side.
  // ---------------------------------------------------------------------------

  // Sends one tick item. The item is held on the channel from a falling edge
  // until the rising edge where the transfer takes place; only then is the
  // shadow model advanced.
  task automatic send_tick(logic [1:0] func, logic [7:0] wbyte, logic line);
    int unsigned    gap;
    owm_pkg::item_t it;
    gap = idle_on ? $urandom_range(0, 5) : 0;
    repeat (gap) begin
      @(negedge clk);
      tick_ch.valid = 1'b0;
    end
    @(negedge clk);
    tick_ch.valid      = 1'b1;
    tick_ch.func       = func;
    tick_ch.write_byte = wbyte;
    tick_ch.line_level = line;
    do @(posedge clk); while (!(tick_ch.valid && tick_ch.ready));
    it.func       = func;
    it.write_byte = wbyte;
    it.line_level = line;
    bus_outcome_q.push_back(advance_bus(it));
    n_ticks++;
  endtask

  // Bus level for a tick: 0 or 1 as given, or random for 2.
  function automatic logic pick_line(int sel);
    return (sel == 2) ? 1'($urandom_range(0, 1)) : 1'(sel);
  endfunction

  // Starts a command from idle and feeds ticks until it has ended. The ticks
  // that follow the first one carry busy_func, which the block must ignore.
  task automatic run_command(logic [1:0] func, logic [7:0] wbyte, int line_sel,
                             logic [1:0] busy_func);
    send_tick(func, wbyte, pick_line(line_sel));
    while (bus_phase != owm_pkg::PH_IDLE) begin
      send_tick(busy_func, 8'($urandom), pick_line(line_sel));
    end
  endtask

  // Takes valid down and holds off until the block has delivered every result.
  task automatic wait_results_drained();
    @(negedge clk);
    tick_ch.valid = 1'b0;
    while (bus_outcome_q.size() != 0) @(posedge clk);
  endtask

  task automatic write_timing_reg(logic [owm_pkg::CfgIdxW-1:0] idx,
                                  logic [owm_pkg::TickW-1:0] val);
    @(negedge clk);
    cfg_we   = 1'b1;
    cfg_idx  = idx;
    cfg_data = val;
    case (idx)
      owm_pkg::REG_RESET_LOW:     timing.reset_low     = val;
      owm_pkg::REG_PRESENCE_WAIT: timing.presence_wait = val;
      owm_pkg::REG_RESET_RECOVER: timing.reset_recover = val;
      owm_pkg::REG_WRITE_ONE_LOW: timing.write_one_low = val;
      owm_pkg::REG_WRITE_SLOT:    timing.write_slot    = val;
      owm_pkg::REG_READ_LOW:      timing.read_low      = val;
      default:                    timing.read_recover  = val;
    endcase
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  // Finishes any running command, lets the pipeline empty, then loads a new
  // set of timing registers.
  task automatic program_timing(owm_pkg::cfg_t c);
    while (bus_phase != owm_pkg::PH_IDLE) begin
      send_tick(owm_pkg::FUNC_TICK, 8'($urandom), pick_line(2));
    end
    wait_results_drained();
    repeat (4) @(posedge clk);
    write_timing_reg(owm_pkg::REG_RESET_LOW, c.reset_low);
    write_timing_reg(owm_pkg::REG_PRESENCE_WAIT, c.presence_wait);
    write_timing_reg(owm_pkg::REG_RESET_RECOVER, c.reset_recover);
    write_timing_reg(owm_pkg::REG_WRITE_ONE_LOW, c.write_one_low);
    write_timing_reg(owm_pkg::REG_WRITE_SLOT, c.write_slot);
    write_timing_reg(owm_pkg::REG_READ_LOW, c.read_low);
    write_timing_reg(owm_pkg::REG_READ_RECOVER, c.read_recover);
    n_settings++;
  endtask

  // Mostly short delays so that many commands fit in the run, with zero and
  // the low bound of one drawn often.
  function automatic logic [owm_pkg::TickW-1:0] draw_ticks();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return 10'd1;
      9:       return 10'($urandom_range(7, 24));
      default: return 10'($urandom_range(1, 6));
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // Tests.
  // ---------------------------------------------------------------------------

  // Registers as they come out of reset: a write of mixed bits, so that both
  // the short one pulse and the long zero pulse are timed.
  task automatic test_reset_values();
    run_command(owm_pkg::FUNC_WRITE, 8'hA5, 2, owm_pkg::FUNC_TICK);
  endtask

  // Zero in every timing register, then each command with a fixed bus level
  // and with other commands arriving while it runs, the done tick included.
  task automatic test_directed_commands();
    owm_pkg::cfg_t c;
    c = '0;
    program_timing(c);
    run_command(owm_pkg::FUNC_RESET, 8'h00, 1, owm_pkg::FUNC_WRITE);
    run_command(owm_pkg::FUNC_RESET, 8'hFF, 0, owm_pkg::FUNC_READ);
    run_command(owm_pkg::FUNC_WRITE, 8'hFF, 1, owm_pkg::FUNC_RESET);
    run_command(owm_pkg::FUNC_READ, 8'h00, 0, owm_pkg::FUNC_WRITE);
    send_tick(owm_pkg::FUNC_TICK, 8'hFF, 1'b1);
    send_tick(owm_pkg::FUNC_TICK, 8'h00, 1'b0);
  endtask

  // Random timing settings, each followed by a stream of ticks in which new
  // commands are started soon after the bus goes idle and stray commands land
  // in the middle of running ones.
  task automatic test_random_traffic();
    owm_pkg::cfg_t c;
    logic [1:0]    func;
    for (int set_no = 0; set_no < 8; set_no++) begin
      c.reset_low     = draw_ticks();
      c.presence_wait = draw_ticks();
      c.reset_recover = draw_ticks();
      c.write_one_low = draw_ticks();
      c.write_slot    = draw_ticks();
      c.read_low      = draw_ticks();
      c.read_recover  = draw_ticks();
      program_timing(c);
      idle_on = (set_no != 2);
      for (int k = 0; k < 100; k++) begin
        // Once, halfway through a setting, the sender holds back until every
        // outstanding result has been delivered.
        if (set_no == 4 && k == 50) wait_results_drained();
        if (bus_phase == owm_pkg::PH_IDLE && $urandom_range(0, 2) == 0) begin
          func = 2'($urandom_range(1, 3));
        end else if ($urandom_range(0, 9) == 0) begin
          func = 2'($urandom_range(0, 3));
        end else begin
          func = owm_pkg::FUNC_TICK;
        end
        send_tick(func, 8'($urandom), pick_line(2));
      end
    end
    idle_on = 1'b1;
  endtask

  // ---------------------------------------------------------------------------
  // Result side: random stalls, then a field-by-field check of each transfer
  // against the oldest result the shadow model produced.
  // ---------------------------------------------------------------------------

  function automatic void check_field(string name, int unsigned want, int unsigned got);
    if (want != got) begin
      $display("%0t: %s expected %0h, got %0h", $time, name, want, got);
      n_errors++;
    end
  endfunction

  initial begin
    int unsigned      stall;
    owm_pkg::result_t want;
    res_ch.ready = 1'b0;
    @(posedge rst_n);
    forever begin
      stall = idle_on ? $urandom_range(0, 5) : 0;
      repeat (stall) begin
        @(negedge clk);
        res_ch.ready = 1'b0;
      end
      @(negedge clk);
      res_ch.ready = 1'b1;
      do @(posedge clk); while (!(res_ch.valid && res_ch.ready));
      if (bus_outcome_q.size() == 0) begin
        $display("%0t: result transfer with none outstanding", $time);
        n_errors++;
      end else begin
        want = bus_outcome_q.pop_front();
        check_field("drive_low", want.drive_low, res_ch.drive_low);
        check_field("busy_res", want.busy_res, res_ch.busy_res);
        check_field("done_res", want.done_res, res_ch.done_res);
        check_field("read_byte", want.read_byte, res_ch.read_byte);
        check_field("presence", want.presence, res_ch.presence);
        n_checked++;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Main sequence.
  // ---------------------------------------------------------------------------

  initial begin
    tick_ch.valid      = 1'b0;
    tick_ch.func       = owm_pkg::FUNC_TICK;
    tick_ch.write_byte = 8'h00;
    tick_ch.line_level = 1'b1;

    // Shadow model starts from the block's reset state.
    timing.reset_low     = owm_pkg::RST_RESET_LOW;
    timing.presence_wait = owm_pkg::RST_PRESENCE_WAIT;
    timing.reset_recover = owm_pkg::RST_RESET_RECOVER;
    timing.write_one_low = owm_pkg::RST_WRITE_ONE_LOW;
    timing.write_slot    = owm_pkg::RST_WRITE_SLOT;
    timing.read_low      = owm_pkg::RST_READ_LOW;
    timing.read_recover  = owm_pkg::RST_READ_RECOVER;
    bus_phase     = owm_pkg::PH_IDLE;
    tick_cnt      = '0;
    bit_idx       = '0;
    shift_reg     = '0;
    presence_seen = 1'b0;
    cmd_kind      = owm_pkg::FUNC_TICK;
    last_read     = '0;

    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    test_reset_values();
    test_directed_commands();
    test_random_traffic();

    // Let the last results come back, then wait for anything stray.
    wait_results_drained();
    repeat (8) @(posedge clk);

    $display("Ran %0d tick items under %0d register settings besides the reset values.",
             n_ticks, n_settings);
    $display("Commands started: %0d resets, %0d writes, %0d reads; %0d results checked.",
             n_resets, n_writes, n_reads, n_checked);
    if (n_errors == 0 && bus_outcome_q.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest passing run, even with maximum idling.
  initial begin
    #(20_000_000);
    $display("Timeout with %0d results outstanding", bus_outcome_q.size());
    $display("Mismatches found");
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/owm_pkg.sv
rtl/owm_if.sv
rtl/owm_cfg.sv
rtl/owm_step.sv
rtl/one_wire_bus_master.sv
rtl/owm_checker.sv
tb/one_wire_bus_master_tb.sv
